FILE: design/kmc_pkg.sv
// shared types and constants of the 2d medoid k-means block
package kmc_pkg;

  localparam int COORD_W   = 16;
  localparam int MAX_CL    = 16;
  localparam int CL_W      = 4;
  localparam int KCNT_W    = 5;
  localparam int ITER_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int SQ_W      = 2 * (COORD_W + 1);
  localparam int DIST_W    = SQ_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT    = 1'b1;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;
  localparam logic REC_CLUSTER = 1'b0;
  localparam logic REC_QUERY   = 1'b1;

  localparam logic [KCNT_W-1:0] CNT_RESET = KCNT_W'(2);
  localparam logic [ITER_W-1:0] LIM_RESET = ITER_W'(256);

  typedef struct packed {
    logic [CL_W-1:0]           lbl;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } pt_word_t;

  typedef struct packed {
    logic load_wr;
    logic rd_pt;
    logic rd_in;
    logic lbl_wr;
    logic lbl_pick;
    logic clr_sums;
    logic clr_cent;
    logic acc;
    logic div_start;
    logic sq_mean;
    logic cent_upd;
    logic sq_cent;
    logic arg_upd;
    logic arg_first;
    logic out_clu;
    logic out_qry;
    logic run_fin;
    logic set_conv;
    logic conv_val;
  } kmc_cmd_t;

  typedef struct packed {
    logic              div_done;
    logic              lbl_chg;
    logic [KCNT_W-1:0] k_eff;
    logic [ITER_W-1:0] lim;
  } kmc_sts_t;

endpackage

FILE: design/kmeans_medoid_clustering_2d.sv
// top level of the 2d k-means block with member-point centroids
// Loads can be accepted back to back; a query is followed by its output transfer.
// After the point marked last, a run clamps the labels below the cluster count, then per
// pass sums the points of each cluster, forms the means (SUM_W = 16 + bits of the point
// count, one quotient bit per cycle), chooses the centroids and reassigns the points,
// then counts the final members and gives one record per cluster. The point memory,
// read one point at a time, sets the per-point cost; no input is taken while a run is
// in progress.
module kmeans_medoid_clustering_2d #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic                                         req_type_i,
  input  logic signed [kmc_pkg::COORD_W-1:0]           point_x_i,
  input  logic signed [kmc_pkg::COORD_W-1:0]           point_y_i,
  input  logic [kmc_pkg::CL_W-1:0]                     initial_cluster_i,
  input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] point_index_i,
  input  logic                                         last_point_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic                                         record_kind_o,
  output logic [kmc_pkg::CL_W-1:0]                     cluster_index_o,
  output logic signed [kmc_pkg::COORD_W-1:0]           centroid_x_o,
  output logic signed [kmc_pkg::COORD_W-1:0]           centroid_y_o,
  output logic [$clog2(MAX_POINTS + 1)-1:0]            member_count_o,
  output logic                                         converged_o,
  output logic                                         last_record_o,
  input  logic                                         cfg_we_i,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [kmc_pkg::CFG_W-1:0]                    cfg_data_i
);

  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  kmc_pkg::kmc_cmd_t        cmd;
  kmc_pkg::kmc_sts_t        sts;
  logic [CNT_W-1:0]         n;
  logic [PIDX_W-1:0]        addr;
  logic [kmc_pkg::CL_W-1:0] cl_sel;

  kmc_ctrl #(.PIDX_W(PIDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .n_i          (n),
    .addr_o       (addr),
    .cl_sel_o     (cl_sel)
  );

  kmc_dp #(.MAX_POINTS(MAX_POINTS), .PIDX_W(PIDX_W), .CNT_W(CNT_W)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .addr_i            (addr),
    .cl_sel_i          (cl_sel),
    .n_o               (n),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .initial_cluster_i (initial_cluster_i),
    .point_index_i     (point_index_i),
    .record_kind_o     (record_kind_o),
    .cluster_index_o   (cluster_index_o),
    .centroid_x_o      (centroid_x_o),
    .centroid_y_o      (centroid_y_o),
    .member_count_o    (member_count_o),
    .converged_o       (converged_o),
    .last_record_o     (last_record_o)
  );

endmodule

FILE: design/kmc_div.sv
// iterative restoring divider, signed dividend, unsigned divisor, one bit per cycle
module kmc_div #(
  parameter int N_W = 27,
  parameter int D_W = 11,
  parameter int Q_W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [N_W-1:0] num_i,
  input  logic [D_W-1:0]        den_i,
  output logic                  done_o,
  output logic signed [Q_W-1:0] quo_o
);

  localparam int C_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic [N_W-1:0] mag_q;
  logic [D_W-1:0] rem_q;
  logic [D_W-1:0] den_q;
  logic [C_W-1:0] cnt_q;
  logic           busy_q;
  logic           neg_q;
  logic           done_q;
  logic [D_W:0]   trial;
  logic           fits;
  logic [N_W-1:0] res;

  assign trial = {rem_q, mag_q[N_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign res   = neg_q ? (~mag_q + N_W'(1)) : mag_q;
  assign quo_o = Q_W'(res);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + C_W'(1);
        if (cnt_q == C_W'(N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[N_W-1];
      mag_q <= num_i[N_W-1] ? (~num_i + N_W'(1)) : num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? D_W'(trial - {1'b0, den_q}) : D_W'(trial);
      mag_q <= {mag_q[N_W-2:0], fits};
    end
  end

endmodule

FILE: design/kmc_dp.sv
// datapath: point memory, per-cluster tables, distance and divide units, output register
module kmc_dp #(
  parameter int MAX_POINTS = 1024,
  parameter int PIDX_W     = 10,
  parameter int CNT_W      = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kmc_pkg::kmc_cmd_t                 cmd_i,
  output kmc_pkg::kmc_sts_t                 sts_o,
  input  logic [PIDX_W-1:0]                 addr_i,
  input  logic [kmc_pkg::CL_W-1:0]          cl_sel_i,
  output logic [CNT_W-1:0]                  n_o,
  input  logic                              cfg_we_i,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [kmc_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic signed [kmc_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [kmc_pkg::COORD_W-1:0] point_y_i,
  input  logic [kmc_pkg::CL_W-1:0]          initial_cluster_i,
  input  logic [PIDX_W-1:0]                 point_index_i,
  output logic                              record_kind_o,
  output logic [kmc_pkg::CL_W-1:0]          cluster_index_o,
  output logic signed [kmc_pkg::COORD_W-1:0] centroid_x_o,
  output logic signed [kmc_pkg::COORD_W-1:0] centroid_y_o,
  output logic [CNT_W-1:0]                  member_count_o,
  output logic                              converged_o,
  output logic                              last_record_o
);

  localparam int CW    = kmc_pkg::COORD_W;
  localparam int SUM_W = CW + CNT_W;
  localparam int NC    = kmc_pkg::MAX_CL;
  localparam int LW    = kmc_pkg::CL_W;
  localparam int KW    = kmc_pkg::KCNT_W;

  kmc_pkg::pt_word_t mem_q [MAX_POINTS];
  kmc_pkg::pt_word_t rd_q;
  kmc_pkg::pt_word_t wr_word;
  logic [PIDX_W-1:0] wr_addr;
  logic              wr_en;
  logic [PIDX_W-1:0] rd_addr;

  logic [KW-1:0]                 cnt_q;
  logic [kmc_pkg::ITER_W-1:0]    lim_q;
  logic [KW-1:0]                 k_eff;
  logic [CNT_W-1:0]              n_q;
  logic                          run_done_q;
  logic [CNT_W-1:0]              base;
  logic                          q_ok_q;
  logic                          conv_q;

  logic signed [SUM_W-1:0] sumx_q [NC];
  logic signed [SUM_W-1:0] sumy_q [NC];
  logic [CNT_W-1:0]        tally_q [NC];
  logic signed [CW-1:0]    meanx_q [NC];
  logic signed [CW-1:0]    meany_q [NC];
  logic signed [CW-1:0]    centx_q [NC];
  logic signed [CW-1:0]    centy_q [NC];
  logic [kmc_pkg::DIST_W-1:0] bestd_q [NC];
  logic [NC-1:0]           bestv_q;

  logic signed [CW-1:0]    refx;
  logic signed [CW-1:0]    refy;
  logic signed [CW:0]      dx;
  logic signed [CW:0]      dy;
  logic signed [kmc_pkg::SQ_W-1:0] sqx;
  logic signed [kmc_pkg::SQ_W-1:0] sqy;
  logic [kmc_pkg::SQ_W-1:0] sqx_q;
  logic [kmc_pkg::SQ_W-1:0] sqy_q;
  logic [kmc_pkg::DIST_W-1:0] dsum;
  logic [kmc_pkg::DIST_W-1:0] argd_q;
  logic [LW-1:0]           pick_q;
  logic [LW-1:0]           dl_q;
  logic [LW-1:0]           lbl_clamp;

  logic                    divx_done;
  logic                    divy_done;
  logic signed [CW-1:0]    qx;
  logic signed [CW-1:0]    qy;

  logic                    rk_q;
  logic [LW-1:0]           ci_q;
  logic signed [CW-1:0]    cx_q;
  logic signed [CW-1:0]    cy_q;
  logic [CNT_W-1:0]        mc_q;
  logic                    cv_q;
  logic                    lr_q;

  // configuration and effective values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= kmc_pkg::CNT_RESET;
      lim_q <= kmc_pkg::LIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kmc_pkg::REG_CLUSTER_COUNT: cnt_q <= cfg_data_i[KW-1:0];
        kmc_pkg::REG_ITER_LIMIT:    lim_q <= cfg_data_i[kmc_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cnt_q == '0) begin
      k_eff = KW'(1);
    end else if (cnt_q > KW'(NC)) begin
      k_eff = KW'(NC);
    end else begin
      k_eff = cnt_q;
    end
  end

  assign sts_o.k_eff    = k_eff;
  assign sts_o.lim      = (lim_q == '0) ? kmc_pkg::ITER_W'(1) : lim_q;
  assign sts_o.div_done = divx_done;
  assign sts_o.lbl_chg  = rd_q.lbl != pick_q;
  assign n_o            = n_q;

  // point count and run state
  assign base = run_done_q ? '0 : n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      run_done_q <= 1'b0;
      conv_q     <= 1'b0;
    end else begin
      if (cmd_i.load_wr) begin
        run_done_q <= 1'b0;
        n_q <= (base < CNT_W'(MAX_POINTS)) ? base + CNT_W'(1) : base;
      end else if (cmd_i.run_fin) begin
        run_done_q <= 1'b1;
      end
      if (cmd_i.set_conv) begin
        conv_q <= cmd_i.conv_val;
      end
    end
  end

  // point memory
  assign lbl_clamp = ({1'b0, rd_q.lbl} >= k_eff) ? LW'(k_eff - KW'(1)) : rd_q.lbl;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_i;
    wr_word = rd_q;
    if (cmd_i.load_wr) begin
      wr_en     = base < CNT_W'(MAX_POINTS);
      wr_addr   = base[PIDX_W-1:0];
      wr_word.x = point_x_i;
      wr_word.y = point_y_i;
      wr_word.lbl = initial_cluster_i;
    end else if (cmd_i.lbl_wr) begin
      wr_en       = 1'b1;
      wr_word.lbl = cmd_i.lbl_pick ? pick_q : lbl_clamp;
    end
  end

  assign rd_addr = cmd_i.rd_in ? point_index_i : addr_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (cmd_i.rd_pt || cmd_i.rd_in) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.rd_in) begin
      q_ok_q <= {{(CNT_W - PIDX_W){1'b0}}, point_index_i} < n_q;
    end
  end

  // distance unit
  assign refx = cmd_i.sq_cent ? centx_q[cl_sel_i] : meanx_q[rd_q.lbl];
  assign refy = cmd_i.sq_cent ? centy_q[cl_sel_i] : meany_q[rd_q.lbl];
  assign dx   = {rd_q.x[CW-1], rd_q.x} - {refx[CW-1], refx};
  assign dy   = {rd_q.y[CW-1], rd_q.y} - {refy[CW-1], refy};
  assign sqx  = dx * dx;
  assign sqy  = dy * dy;
  assign dsum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mean || cmd_i.sq_cent) begin
      sqx_q <= sqx;
      sqy_q <= sqy;
      dl_q  <= cl_sel_i;
    end
    if (cmd_i.arg_upd && (cmd_i.arg_first || dsum < argd_q)) begin
      argd_q <= dsum;
      pick_q <= dl_q;
    end
  end

  // dividers for the means
  kmc_div #(.N_W(SUM_W), .D_W(CNT_W), .Q_W(CW)) u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sumx_q[cl_sel_i]),
    .den_i   (tally_q[cl_sel_i]),
    .done_o  (divx_done),
    .quo_o   (qx)
  );

  kmc_div #(.N_W(SUM_W), .D_W(CNT_W), .Q_W(CW)) u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (sumy_q[cl_sel_i]),
    .den_i   (tally_q[cl_sel_i]),
    .done_o  (divy_done),
    .quo_o   (qy)
  );

  // per-cluster tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_sums) begin
      for (int j = 0; j < NC; j++) begin
        sumx_q[j]  <= '0;
        sumy_q[j]  <= '0;
        tally_q[j] <= '0;
      end
    end else if (cmd_i.acc) begin
      sumx_q[rd_q.lbl]  <= sumx_q[rd_q.lbl] + SUM_W'(rd_q.x);
      sumy_q[rd_q.lbl]  <= sumy_q[rd_q.lbl] + SUM_W'(rd_q.y);
      tally_q[rd_q.lbl] <= tally_q[rd_q.lbl] + CNT_W'(1);
    end
    if (divx_done && divy_done) begin
      meanx_q[cl_sel_i] <= (tally_q[cl_sel_i] == '0) ? '0 : qx;
      meany_q[cl_sel_i] <= (tally_q[cl_sel_i] == '0) ? '0 : qy;
    end
    if (cmd_i.clr_cent) begin
      for (int j = 0; j < NC; j++) begin
        centx_q[j] <= '0;
        centy_q[j] <= '0;
        bestd_q[j] <= '0;
      end
      bestv_q <= '0;
    end else if (cmd_i.cent_upd) begin
      if (!bestv_q[rd_q.lbl] || dsum < bestd_q[rd_q.lbl]) begin
        bestv_q[rd_q.lbl] <= 1'b1;
        bestd_q[rd_q.lbl] <= dsum;
        centx_q[rd_q.lbl] <= rd_q.x;
        centy_q[rd_q.lbl] <= rd_q.y;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_clu) begin
      rk_q <= kmc_pkg::REC_CLUSTER;
      ci_q <= cl_sel_i;
      cx_q <= centx_q[cl_sel_i];
      cy_q <= centy_q[cl_sel_i];
      mc_q <= tally_q[cl_sel_i];
      cv_q <= conv_q;
      lr_q <= ({1'b0, cl_sel_i} + KW'(1)) == k_eff;
    end else if (cmd_i.out_qry) begin
      rk_q <= kmc_pkg::REC_QUERY;
      ci_q <= q_ok_q ? rd_q.lbl : '0;
      cx_q <= '0;
      cy_q <= '0;
      mc_q <= '0;
      cv_q <= 1'b0;
      lr_q <= 1'b1;
    end
  end

  assign record_kind_o   = rk_q;
  assign cluster_index_o = ci_q;
  assign centroid_x_o    = cx_q;
  assign centroid_y_o    = cy_q;
  assign member_count_o  = mc_q;
  assign converged_o     = cv_q;
  assign last_record_o   = lr_q;

endmodule

FILE: design/kmc_ctrl.sv
// controller: sequences loads, queries, clustering passes and record output
module kmc_ctrl #(
  parameter int PIDX_W = 10,
  parameter int CNT_W  = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic                     last_point_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output kmc_pkg::kmc_cmd_t        cmd_o,
  input  kmc_pkg::kmc_sts_t        sts_i,
  input  logic [CNT_W-1:0]         n_i,
  output logic [PIDX_W-1:0]        addr_o,
  output logic [kmc_pkg::CL_W-1:0] cl_sel_o
);

  localparam int KW = kmc_pkg::KCNT_W;
  localparam int IW = kmc_pkg::ITER_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_Q_OUT, ST_CL_RD, ST_CL_WR, ST_P_START, ST_A_RD, ST_A_ADD,
    ST_M_DIV, ST_M_WAIT, ST_C_RD, ST_C_SQ, ST_C_UPD, ST_S_RD, ST_S_SQ,
    ST_S_CMP, ST_S_WR, ST_P_END, ST_F_START, ST_E_OUT, ST_E_WAIT
  } state_e;

  state_e         state_q;
  logic [CNT_W-1:0] pt_q;
  logic [KW-1:0]  cl_q;
  logic [IW-1:0]  pass_q;
  logic [IW:0]    pass_nx;
  logic           chg_q;
  logic           fin_q;
  logic           out_valid_q;
  logic           in_xfer;
  logic           pt_end;
  logic           cl_last;

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign pt_end      = pt_q == n_i;
  assign cl_last     = (cl_q + KW'(1)) == sts_i.k_eff;
  assign pass_nx     = {1'b0, pass_q} + (IW + 1)'(1);
  assign addr_o      = pt_q[PIDX_W-1:0];
  assign cl_sel_o    = cl_q[kmc_pkg::CL_W-1:0];

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_wr = in_xfer && (req_type_i == kmc_pkg::REQ_LOAD);
        cmd_o.rd_in   = in_xfer && (req_type_i == kmc_pkg::REQ_QUERY);
      end
      ST_Q_OUT: cmd_o.out_qry = 1'b1;
      ST_CL_RD: cmd_o.rd_pt = !pt_end;
      ST_CL_WR: cmd_o.lbl_wr = 1'b1;
      ST_P_START: begin
        cmd_o.clr_sums = 1'b1;
        cmd_o.clr_cent = 1'b1;
      end
      ST_A_RD:   cmd_o.rd_pt = !pt_end;
      ST_A_ADD:  cmd_o.acc = 1'b1;
      ST_M_DIV:  cmd_o.div_start = cl_q != sts_i.k_eff;
      ST_C_RD:   cmd_o.rd_pt = !pt_end;
      ST_C_SQ:   cmd_o.sq_mean = 1'b1;
      ST_C_UPD:  cmd_o.cent_upd = 1'b1;
      ST_S_RD:   cmd_o.rd_pt = !pt_end;
      ST_S_SQ:   cmd_o.sq_cent = 1'b1;
      ST_S_CMP: begin
        cmd_o.arg_upd   = 1'b1;
        cmd_o.arg_first = cl_q == '0;
      end
      ST_S_WR: begin
        cmd_o.lbl_wr   = 1'b1;
        cmd_o.lbl_pick = 1'b1;
      end
      ST_F_START: begin
        cmd_o.clr_sums = 1'b1;
        cmd_o.set_conv = 1'b1;
        cmd_o.conv_val = !chg_q;
        cmd_o.run_fin  = 1'b1;
      end
      ST_E_OUT: cmd_o.out_clu = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pt_q        <= '0;
      cl_q        <= '0;
      pass_q      <= '0;
      chg_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_clu || cmd_o.out_qry) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (req_type_i == kmc_pkg::REQ_QUERY) begin
              state_q <= ST_Q_OUT;
            end else if (last_point_i) begin
              state_q <= ST_CL_RD;
              pt_q    <= '0;
              pass_q  <= '0;
              fin_q   <= 1'b0;
            end
          end
        end
        ST_Q_OUT: state_q <= ST_IDLE;
        ST_CL_RD: state_q <= pt_end ? ST_P_START : ST_CL_WR;
        ST_CL_WR: begin
          pt_q    <= pt_q + CNT_W'(1);
          state_q <= ST_CL_RD;
        end
        ST_P_START: begin
          pt_q    <= '0;
          chg_q   <= 1'b0;
          state_q <= ST_A_RD;
        end
        ST_A_RD: begin
          if (pt_end) begin
            cl_q    <= '0;
            state_q <= fin_q ? ST_E_OUT : ST_M_DIV;
          end else begin
            state_q <= ST_A_ADD;
          end
        end
        ST_A_ADD: begin
          pt_q    <= pt_q + CNT_W'(1);
          state_q <= ST_A_RD;
        end
        ST_M_DIV: begin
          if (cl_q == sts_i.k_eff) begin
            pt_q    <= '0;
            state_q <= ST_C_RD;
          end else begin
            state_q <= ST_M_WAIT;
          end
        end
        ST_M_WAIT: begin
          if (sts_i.div_done) begin
            cl_q    <= cl_q + KW'(1);
            state_q <= ST_M_DIV;
          end
        end
        ST_C_RD: begin
          if (pt_end) begin
            pt_q    <= '0;
            state_q <= ST_S_RD;
          end else begin
            state_q <= ST_C_SQ;
          end
        end
        ST_C_SQ: state_q <= ST_C_UPD;
        ST_C_UPD: begin
          pt_q    <= pt_q + CNT_W'(1);
          state_q <= ST_C_RD;
        end
        ST_S_RD: begin
          if (pt_end) begin
            state_q <= ST_P_END;
          end else begin
            cl_q    <= '0;
            state_q <= ST_S_SQ;
          end
        end
        ST_S_SQ: state_q <= ST_S_CMP;
        ST_S_CMP: begin
          if (cl_last) begin
            state_q <= ST_S_WR;
          end else begin
            cl_q    <= cl_q + KW'(1);
            state_q <= ST_S_SQ;
          end
        end
        ST_S_WR: begin
          if (sts_i.lbl_chg) begin
            chg_q <= 1'b1;
          end
          pt_q    <= pt_q + CNT_W'(1);
          state_q <= ST_S_RD;
        end
        ST_P_END: begin
          pass_q <= pass_nx[IW-1:0];
          if (chg_q && (pass_nx < {1'b0, sts_i.lim})) begin
            state_q <= ST_P_START;
          end else begin
            fin_q   <= 1'b1;
            state_q <= ST_F_START;
          end
        end
        ST_F_START: begin
          pt_q    <= '0;
          state_q <= ST_A_RD;
        end
        ST_E_OUT: state_q <= ST_E_WAIT;
        ST_E_WAIT: begin
          if (out_ready_i) begin
            if (cl_last) begin
              state_q <= ST_IDLE;
            end else begin
              cl_q    <= cl_q + KW'(1);
              state_q <= ST_E_OUT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
